// ----- design/pts_pkg.sv -----
package pts_pkg;

	localparam int unsigned THREAD_COUNT_DEF = 16;
	localparam logic [7:0] PRIO_NONE = 8'd255;
	localparam logic [7:0] PRIO_FLOOR = 8'd1;
	localparam logic [7:0] SLICE_RST = 8'd10;
	localparam logic [7:0] AGING_RST = 8'd50;
	// floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	typedef enum logic [2:0] {
		ST_UNUSED   = 3'd0,
		ST_READY    = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_BLOCKED  = 3'd3,
		ST_SLEEPING = 3'd4,
		ST_DEAD     = 3'd5
	} ent_state_t;

	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_BLOCK     = 3'd1,
		ACT_UNBLOCK   = 3'd2,
		ACT_SLEEP     = 3'd3,
		ACT_TERMINATE = 3'd4,
		ACT_ADMIT     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_SLICE  = 2'd1,
		REG_AGING  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SLEEP,
		FSM_CHARGE,
		FSM_WAKE,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_AGE,
		OP_WAKE,
		OP_SET,
		OP_SLEEP,
		OP_RUN,
		OP_DEC,
		OP_ADMIT
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		ent_state_t st;
		logic [7:0] prio;
		logic [7:0] quantum;
		logic [31:0] wake;
	} cell_cmd_t;

endpackage

// ----- design/priority_thread_scheduler.sv -----
// Event-driven thread scheduler over a row of thread cells. One event is taken
// when start is high and busy is low; its result appears for exactly one cycle
// with done high and cannot be stalled, so the receiver must take it then.
// Unblock, admit, unknown actions and disabled ticks go from exec to done; ticks that
// only charge the quantum pass charge. Block and terminate pass wake and scan; sleep
// and ticks that pick pass sleep or charge, then wake and scan: the pick passes a best
// candidate word down the chain of cells, one cell per cycle.
// Configuration writes are always ready and should be made while busy is low.
module priority_thread_scheduler #(
	parameter int unsigned THREAD_COUNT = pts_pkg::THREAD_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [3:0]  thread_id,
	input  logic [7:0]  thread_priority,
	input  logic [31:0] sleep_ms,
	output logic        done,
	output logic [3:0]  running_tid,
	output logic [3:0]  previous_tid,
	output logic        switched,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import pts_pkg::*;

	localparam int unsigned IDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

	fsm_t fsm_q, fsm_nxt;
	logic        enable_q;
	logic [7:0]  slice_q;
	logic [7:0]  aging_per_q;
	logic [7:0]  aging_q;
	logic [31:0] tick_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] prev_q;
	logic [2:0]  act_q;
	logic [3:0]  tid_q;
	logic [7:0]  prio_q;
	logic [31:0] ms_q;
	logic [63:0] prod_s1;
	logic        inj_q;

	cell_cmd_t   cmd;
	logic [IDX_W-1:0] tgt_idx;
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] tid_idx;
	logic        tid_ok;
	ent_state_t  sel_st;
	logic [7:0]  sel_quant;
	logic [7:0]  aging_inc;
	logic [28:0] ticks;
	logic [IDX_W-1:0] pick;
	logic        do_run;
	logic        is_tick;
	logic        accept;

	ent_state_t  st_arr [THREAD_COUNT];
	logic [7:0]  qt_arr [THREAD_COUNT];
	logic        sc_vld  [THREAD_COUNT+1];
	logic [7:0]  sc_prio [THREAD_COUNT+1];
	logic [IDX_W-1:0] sc_idx [THREAD_COUNT+1];

	assign accept = start && !busy;
	assign busy = (fsm_q != FSM_IDLE);
	assign cfg_ready = 1'b1;
	assign tid_idx = IDX_W'(tid_q);
	assign tid_ok = 32'(tid_q) < THREAD_COUNT;
	assign is_tick = (act_q == ACT_TICK);
	assign aging_inc = aging_q + 8'd1;
	assign ticks = (prod_s1[63:RECIP_SHIFT] == '0) ? 29'd1 : prod_s1[63:RECIP_SHIFT];

	assign sel_idx = (fsm_q == FSM_EXEC && (act_q == ACT_UNBLOCK || act_q == ACT_ADMIT))
		? tid_idx : cur_q;
	assign sel_st = st_arr[sel_idx];
	assign sel_quant = qt_arr[sel_idx];

	assign sc_vld[0] = inj_q;
	assign sc_prio[0] = PRIO_NONE;
	assign sc_idx[0] = '0;

	assign pick = (sc_idx[THREAD_COUNT] == '0 && sel_st == ST_RUNNING)
		? cur_q : sc_idx[THREAD_COUNT];
	assign do_run = (pick != cur_q) || (is_tick && sel_st == ST_READY);

	for (genvar g = 0; g < THREAD_COUNT; g++) begin : g_cell
		pts_cell #(
			.IDX_W(IDX_W),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.hit(tgt_idx == IDX_W'(g)),
			.tick_count(tick_q),
			.cur_idx(cur_q),
			.sc_vld_i(sc_vld[g]),
			.sc_prio_i(sc_prio[g]),
			.sc_idx_i(sc_idx[g]),
			.sc_vld_o(sc_vld[g+1]),
			.sc_prio_o(sc_prio[g+1]),
			.sc_idx_o(sc_idx[g+1]),
			.state_o(st_arr[g]),
			.quantum_o(qt_arr[g])
		);
	end

	always_comb begin
		fsm_nxt = fsm_q;
		case (fsm_q)
			FSM_IDLE: if (accept) fsm_nxt = FSM_EXEC;
			FSM_EXEC: begin
				case (act_q)
					ACT_TICK:      fsm_nxt = enable_q ? FSM_CHARGE : FSM_DONE;
					ACT_BLOCK:     fsm_nxt = FSM_WAKE;
					ACT_SLEEP:     fsm_nxt = FSM_SLEEP;
					ACT_TERMINATE: fsm_nxt = FSM_WAKE;
					default:       fsm_nxt = FSM_DONE;
				endcase
			end
			FSM_SLEEP: fsm_nxt = FSM_WAKE;
			FSM_CHARGE: begin
				if (sel_st == ST_RUNNING && sel_quant > 8'd1)
					fsm_nxt = FSM_DONE;
				else
					fsm_nxt = FSM_WAKE;
			end
			FSM_WAKE: fsm_nxt = FSM_SCAN;
			FSM_SCAN: if (sc_vld[THREAD_COUNT]) fsm_nxt = FSM_DONE;
			FSM_DONE: fsm_nxt = FSM_IDLE;
			default:  fsm_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{op: OP_NONE, st: ST_UNUSED, prio: prio_q, quantum: slice_q,
			wake: tick_q + 32'(ticks)};
		tgt_idx = sel_idx;
		case (fsm_q)
			FSM_EXEC: begin
				case (act_q)
					ACT_TICK: begin
						if (enable_q && aging_inc >= aging_per_q)
							cmd.op = OP_AGE;
					end
					ACT_BLOCK: begin
						cmd.op = OP_SET;
						cmd.st = ST_BLOCKED;
						cmd.quantum = sel_quant;
					end
					ACT_UNBLOCK: begin
						if (tid_ok && sel_st == ST_BLOCKED) begin
							cmd.op = OP_SET;
							cmd.st = ST_READY;
							cmd.quantum = sel_quant;
						end
					end
					ACT_TERMINATE: begin
						cmd.op = OP_SET;
						cmd.st = ST_DEAD;
						cmd.quantum = sel_quant;
					end
					ACT_ADMIT: begin
						if (tid_ok && (sel_st == ST_UNUSED || sel_st == ST_DEAD))
							cmd.op = OP_ADMIT;
					end
					default: ;
				endcase
			end
			FSM_SLEEP: cmd.op = OP_SLEEP;
			FSM_CHARGE: begin
				if (sel_st == ST_RUNNING) begin
					if (sel_quant > 8'd1) begin
						cmd.op = OP_DEC;
					end else begin
						cmd.op = OP_SET;
						cmd.st = ST_READY;
					end
				end
			end
			FSM_WAKE: cmd.op = OP_WAKE;
			FSM_SCAN: begin
				tgt_idx = pick;
				if (sc_vld[THREAD_COUNT] && do_run)
					cmd.op = OP_RUN;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
			enable_q <= 1'b0;
			slice_q <= SLICE_RST;
			aging_per_q <= AGING_RST;
			aging_q <= '0;
			tick_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			inj_q <= 1'b0;
		end else begin
			fsm_q <= fsm_nxt;
			inj_q <= (fsm_q == FSM_WAKE);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE: enable_q <= cfg_data[0];
					REG_SLICE:  slice_q <= cfg_data;
					REG_AGING:  aging_per_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept)
				prev_q <= cur_q;
			if (fsm_q == FSM_EXEC && act_q == ACT_TICK && enable_q) begin
				tick_q <= tick_q + 32'd1;
				aging_q <= (aging_inc >= aging_per_q) ? 8'd0 : aging_inc;
			end
			if (fsm_q == FSM_SCAN && sc_vld[THREAD_COUNT] && do_run)
				cur_q <= pick;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			tid_q <= thread_id;
			prio_q <= thread_priority;
			ms_q <= sleep_ms;
		end
		prod_s1 <= 64'(ms_q) * 64'(RECIP_10);
	end

	assign done = (fsm_q == FSM_DONE);
	assign running_tid = 4'(cur_q);
	assign previous_tid = 4'(prev_q);
	assign switched = (cur_q != prev_q);

endmodule

// ----- design/pts_cell.sv -----
module pts_cell #(
	parameter int unsigned IDX_W = 4,
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::cell_cmd_t cmd,
	input  logic              hit,
	input  logic [31:0]       tick_count,
	input  logic [IDX_W-1:0]  cur_idx,
	input  logic              sc_vld_i,
	input  logic [7:0]        sc_prio_i,
	input  logic [IDX_W-1:0]  sc_idx_i,
	output logic              sc_vld_o,
	output logic [7:0]        sc_prio_o,
	output logic [IDX_W-1:0]  sc_idx_o,
	output pts_pkg::ent_state_t state_o,
	output logic [7:0]        quantum_o
);
	import pts_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	ent_state_t  state_q;
	logic [7:0]  prio_q;
	logic [7:0]  quantum_q;
	logic [31:0] wake_q;
	logic        sc_vld_q;
	logic [7:0]  sc_prio_q;
	logic [IDX_W-1:0] sc_idx_q;
	logic        cand;

	assign cand = (state_q == ST_READY) && (cur_idx != MY_IDX) && (prio_q < sc_prio_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= (IDX == 0) ? ST_RUNNING : ST_UNUSED;
			prio_q <= '0;
			quantum_q <= '0;
			wake_q <= '0;
			sc_vld_q <= 1'b0;
		end else begin
			sc_vld_q <= sc_vld_i;
			case (cmd.op)
				OP_AGE: begin
					if (IDX != 0 && state_q == ST_READY && prio_q > PRIO_FLOOR)
						prio_q <= prio_q - 8'd1;
				end
				OP_WAKE: begin
					if (state_q == ST_SLEEPING && tick_count >= wake_q)
						state_q <= ST_READY;
				end
				OP_SET: begin
					if (hit) begin
						state_q <= cmd.st;
						quantum_q <= cmd.quantum;
					end
				end
				OP_SLEEP: begin
					if (hit) begin
						state_q <= ST_SLEEPING;
						wake_q <= cmd.wake;
					end
				end
				OP_RUN: begin
					if (hit) begin
						state_q <= ST_RUNNING;
						quantum_q <= cmd.quantum;
					end
				end
				OP_DEC: begin
					if (hit)
						quantum_q <= quantum_q - 8'd1;
				end
				OP_ADMIT: begin
					if (hit) begin
						state_q <= ST_READY;
						prio_q <= cmd.prio;
						quantum_q <= cmd.quantum;
						wake_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			sc_prio_q <= prio_q;
			sc_idx_q <= MY_IDX;
		end else begin
			sc_prio_q <= sc_prio_i;
			sc_idx_q <= sc_idx_i;
		end
	end

	assign sc_vld_o = sc_vld_q;
	assign sc_prio_o = sc_prio_q;
	assign sc_idx_o = sc_idx_q;
	assign state_o = state_q;
	assign quantum_o = quantum_q;

endmodule
